[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled during reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check, always active.
`define ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/lgbm_pkg.sv]
`default_nettype none
package lgbm_pkg;
  localparam int unsigned DefaultWidth = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;       // capture operands
    logic div_start;  // begin a division of the current dividend/divisor
    logic mul_start;  // begin quotient * multiple accumulate
    logic step;       // commit remainder and accumulated multiple, swap phase
    logic finish;     // latch results into output register
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic mul_busy;
    logic bad;        // c is zero (c is loaded from the first value)
    logic rem_zero;   // last remainder was zero
  } sts_t;
endpackage
`default_nettype wire

[rtl/lcm_gcd_bezout_multiple.sv]
// Channel | Handshake              | Word
// --------+------------------------+---------------------------------------------
// in      | in_valid_i/in_ready_o  | first_value_i, second_value_i
// out     | out_valid_o/out_ready_i| least_multiple_o, greatest_divisor_o,
//         |                        | multiple_of_first_o, bad_input_o
// One word at a time. Each Euclid half-step is a restoring divide followed by a
// shift-add multiply that adds quotient times multiple onto the other multiple.
// rst_ni clears the controller and output valid. A stalled output word holds
// until taken; a new input word is taken once the previous result is latched.
`default_nettype none
module lcm_gcd_bezout_multiple #(
  parameter int unsigned Width = lgbm_pkg::DefaultWidth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] first_value_i,
  input  wire logic [63:0] second_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      least_multiple_o,
  output logic [63:0]      greatest_divisor_o,
  output logic [63:0]      multiple_of_first_o,
  output logic             bad_input_o
);
  lgbm_pkg::cmd_t   cmd;
  lgbm_pkg::sts_t   sts;
  logic [Width-1:0] lcm, gcd, mul;

  lgbm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd), .bad_o(bad_input_o)
  );

  lgbm_datapath #(.Width(Width)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .first_value_i, .second_value_i,
    .lcm_o(lcm), .gcd_o(gcd), .mul_o(mul)
  );

  // zero-extend to the fixed 64-bit ports
  assign least_multiple_o    = 64'(lcm);
  assign greatest_divisor_o  = 64'(gcd);
  assign multiple_of_first_o = 64'(mul);
endmodule
`default_nettype wire

[rtl/lgbm_datapath.sv]
`default_nettype none
module lgbm_datapath #(
  parameter int unsigned Width = lgbm_pkg::DefaultWidth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lgbm_pkg::cmd_t    cmd_i,
  output lgbm_pkg::sts_t         sts_o,
  input  wire logic [63:0]       first_value_i,
  input  wire logic [63:0]       second_value_i,
  output logic [Width-1:0]       lcm_o,
  output logic [Width-1:0]       gcd_o,
  output logic [Width-1:0]       mul_o
);
  localparam int unsigned CntW = $clog2(Width + 1);

  // phase_q = 0: d := d mod c, md += (d/c)*mc ; phase_q = 1: roles swapped
  logic [Width-1:0] c_q, d_q, mc_q, md_q;
  logic             phase_q;
  logic [Width-1:0] rem_q, quo_q, dvs_q;
  logic [CntW-1:0]  dcnt_q;
  logic             div_busy_q;
  logic [Width-1:0] acc_q, mcand_q, mplier_q;
  logic [CntW-1:0]  mcnt_q;
  logic             mul_busy_q;
  logic             rz_q;

  logic [Width-1:0] dividend, divisor, mult;
  logic [Width:0]   trial;
  logic [Width-1:0] rem_sh;

  assign dividend = phase_q ? c_q : d_q;
  assign divisor  = phase_q ? d_q : c_q;
  assign mult     = phase_q ? md_q : mc_q;

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_q[Width-2:0], quo_q[Width-1]};
  assign trial  = {rem_q, quo_q[Width-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      dcnt_q     <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      dcnt_q     <= CntW'(Width);
    end else if (div_busy_q) begin
      dcnt_q <= dcnt_q - CntW'(1);
      if (dcnt_q == CntW'(1)) div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= dividend;
      dvs_q <= divisor;
    end else if (div_busy_q) begin
      if (!trial[Width]) begin
        rem_q <= trial[Width-1:0];
        quo_q <= {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[Width-2:0], 1'b0};
      end
    end
  end

  // shift-add multiplier, one bit per cycle, accumulates onto target multiple
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mcnt_q     <= '0;
    end else if (cmd_i.mul_start) begin
      mul_busy_q <= 1'b1;
      mcnt_q     <= CntW'(Width);
    end else if (mul_busy_q) begin
      mcnt_q <= mcnt_q - CntW'(1);
      if (mcnt_q == CntW'(1)) mul_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      acc_q    <= phase_q ? mc_q : md_q;
      mcand_q  <= mult;
      mplier_q <= quo_q;
    end else if (mul_busy_q) begin
      if (mplier_q[0]) acc_q <= acc_q + mcand_q;
      mcand_q  <= {mcand_q[Width-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[Width-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      rz_q    <= 1'b0;
    end else if (cmd_i.load) begin
      phase_q <= 1'b0;
      rz_q    <= 1'b0;
    end else if (cmd_i.step) begin
      rz_q    <= (rem_q == '0);
      phase_q <= ~phase_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q  <= first_value_i[Width-1:0];
      d_q  <= second_value_i[Width-1:0];
      mc_q <= first_value_i[Width-1:0];
      md_q <= '0;
    end else if (cmd_i.step) begin
      if (phase_q) begin
        c_q  <= rem_q;
        mc_q <= acc_q;
      end else begin
        d_q  <= rem_q;
        md_q <= acc_q;
      end
    end
  end

  // after a step phase_q has toggled: phase 1 means d just hit zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (c_q == '0 && !rz_q) begin
        lcm_o <= '0; gcd_o <= '0; mul_o <= '0;
      end else if (phase_q) begin
        lcm_o <= md_q; gcd_o <= c_q; mul_o <= mc_q;
      end else begin
        lcm_o <= mc_q; gcd_o <= d_q;
        mul_o <= (md_q == '0) ? '0 : mc_q - md_q;
      end
    end
  end

  assign sts_o.div_busy = div_busy_q;
  assign sts_o.mul_busy = mul_busy_q;
  assign sts_o.bad      = (c_q == '0);
  assign sts_o.rem_zero = rz_q;

  `include "assert_macros.svh"
  `ASSERT_RST(a_not_both, clk_i, rst_ni, !(div_busy_q && mul_busy_q), "div and mul overlap")
  `ASSERT_RST(a_mul_after_div, clk_i, rst_ni, cmd_i.mul_start |-> !div_busy_q, "mul early")
  `ASSERT_RST(a_dcnt, clk_i, rst_ni, div_busy_q |-> dcnt_q != '0, "div count")
endmodule
`default_nettype wire

[rtl/lgbm_ctrl.sv]
`default_nettype none
module lgbm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire lgbm_pkg::sts_t sts_i,
  output lgbm_pkg::cmd_t      cmd_o,
  output logic                bad_o
);
  lgbm_pkg::state_e state_q, state_d;
  logic ov_q, bad_q;
  logic accept;

  // output register frees when taken, can refill as the result is taken
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == lgbm_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lgbm_pkg::ST_IDLE:  if (accept) state_d = lgbm_pkg::ST_CHECK;
      lgbm_pkg::ST_CHECK: begin
        if (sts_i.bad || sts_i.rem_zero) state_d = lgbm_pkg::ST_DONE;
        else state_d = lgbm_pkg::ST_DIV;
      end
      lgbm_pkg::ST_DIV:   if (!sts_i.div_busy) state_d = lgbm_pkg::ST_MUL;
      lgbm_pkg::ST_MUL:   if (!sts_i.mul_busy) state_d = lgbm_pkg::ST_CHECK;
      lgbm_pkg::ST_DONE:  if (!ov_q || out_ready_i) state_d = lgbm_pkg::ST_IDLE;
      default:            state_d = lgbm_pkg::ST_IDLE;
    endcase
  end

  // accepting loads; entering DIV/MUL issue start; leaving MUL commits; DONE latches results
  always_comb begin
    cmd_o = '0;
    cmd_o.load = accept;
    unique case (state_q)
      lgbm_pkg::ST_CHECK: cmd_o.div_start = !(sts_i.bad || sts_i.rem_zero);
      lgbm_pkg::ST_DIV:   cmd_o.mul_start = !sts_i.div_busy;
      lgbm_pkg::ST_MUL:   cmd_o.step = !sts_i.mul_busy;
      lgbm_pkg::ST_DONE:  cmd_o.finish = !ov_q || out_ready_i;
      default:            ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lgbm_pkg::ST_IDLE;
      ov_q    <= 1'b0;
      bad_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.finish) begin
        ov_q  <= 1'b1;
        bad_q <= sts_i.bad && !sts_i.rem_zero;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign bad_o       = bad_q;

  `include "assert_macros.svh"
  `ASSERT_RST(a_load_idle, clk_i, rst_ni, cmd_o.load |-> state_q == lgbm_pkg::ST_IDLE, "load")
  `ASSERT_RST(a_fin_room, clk_i, rst_ni, cmd_o.finish |-> (!ov_q || out_ready_i), "overrun")
  `ASSERT_RST(a_step_idle, clk_i, rst_ni, cmd_o.step |=> !sts_i.mul_busy, "step")
endmodule
`default_nettype wire
